// ----- design/gbcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbcs_pkg
// Shared types and constants for the glyph blit command stream.
// ----------------------------------------------------------------------------
package gbcs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    // tuser bit positions on the result side
    localparam int unsigned TUSER_IS_CMD = 0;
    localparam int unsigned TUSER_DONE = 1;
    localparam int unsigned M_TUSER_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_CMD_BASE = 3'd0,
        REG_COL_LOW_CMD_BASE = 3'd1,
        REG_COL_HIGH_CMD_BASE = 3'd2,
        REG_START_PAGE = 3'd3,
        REG_START_COLUMN = 3'd4,
        REG_GLYPH_WIDTH = 3'd5,
        REG_GLYPH_HEIGHT = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] page_cmd_base;
        logic [BYTE_W-1:0] col_low_cmd_base;
        logic [BYTE_W-1:0] col_high_cmd_base;
        logic [BYTE_W-1:0] start_page;
        logic [BYTE_W-1:0] start_column;
        logic [BYTE_W-1:0] glyph_width;
        logic [BYTE_W-1:0] glyph_height;
    } cfg_t;

    // one classified request: everything the back end needs for eight bytes
    typedef struct packed {
        logic [BYTE_W-1:0] page_cmd;
        logic [BYTE_W-1:0] col_lo_cmd;
        logic [BYTE_W-1:0] col_hi_cmd;
        logic [BYTE_W-1:0] data_hi;
        logic [BYTE_W-1:0] data_lo;
        logic              done;
    } desc_t;

endpackage

// ----- design/gbcs_front.sv -----
// ----------------------------------------------------------------------------
// gbcs_front
// Accepts pixel bytes, steps the glyph counters and builds the command set.
// ----------------------------------------------------------------------------
module gbcs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gbcs_pkg::cfg_t        cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel_byte
    input  logic [0:0]            s_tuser,   // [0] glyph_start
    input  logic                  q_full,
    output logic                  q_push,
    output gbcs_pkg::desc_t       q_desc
);
    import gbcs_pkg::*;

    logic [BYTE_W-1:0] inner_reg, inner_next;
    logic [BYTE_W-1:0] outer_reg, outer_next;
    logic [BYTE_W-1:0] inner_eff, outer_eff;
    logic [BYTE_W-1:0] col, page0;
    logic [BYTE_W:0]   inner_inc, outer_inc;
    logic              wrap_inner, wrap_outer;

    function automatic logic [BYTE_W-1:0] widen(input logic [3:0] nib);
        logic [BYTE_W-1:0] v;
        v = '0;
        if (nib[0]) v = v | 8'hC0;
        if (nib[1]) v = v | 8'h30;
        if (nib[2]) v = v | 8'h0C;
        if (nib[3]) v = v | 8'h03;
        return v;
    endfunction

    assign s_tready = !q_full;
    assign q_push = s_tvalid && !q_full;

    always_comb begin
        inner_eff = s_tuser[0] ? '0 : inner_reg;
        outer_eff = s_tuser[0] ? '0 : outer_reg;
        col = cfg.start_column + outer_eff;
        page0 = cfg.start_page + {inner_eff[BYTE_W-2:0], 1'b0};

        inner_inc = {1'b0, inner_eff} + 9'd1;
        outer_inc = {1'b0, outer_eff} + 9'd1;
        wrap_inner = inner_inc >= {1'b0, cfg.glyph_width};
        wrap_outer = wrap_inner && (outer_inc >= {1'b0, cfg.glyph_height});

        inner_next = wrap_inner ? '0 : inner_inc[BYTE_W-1:0];
        outer_next = outer_eff;
        if (wrap_inner) begin
            outer_next = wrap_outer ? '0 : outer_inc[BYTE_W-1:0];
        end

        q_desc.page_cmd = cfg.page_cmd_base + page0;
        q_desc.col_lo_cmd = cfg.col_low_cmd_base + {4'd0, col[3:0]};
        q_desc.col_hi_cmd = cfg.col_high_cmd_base + {4'd0, col[7:4]};
        q_desc.data_hi = widen(s_tdata[7:4]);
        q_desc.data_lo = widen(s_tdata[3:0]);
        q_desc.done = wrap_outer;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg <= '0;
            outer_reg <= '0;
        end else if (q_push) begin
            inner_reg <= inner_next;
            outer_reg <= outer_next;
        end
    end

endmodule

// ----- design/gbcs_queue.sv -----
// ----------------------------------------------------------------------------
// gbcs_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module gbcs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  gbcs_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output gbcs_pkg::desc_t head
);
    import gbcs_pkg::*;

    desc_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full = count_reg == QCNT_W'(QDEPTH);
    assign empty = count_reg == '0;
    assign head = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

// ----- design/gbcs_back.sv -----
// ----------------------------------------------------------------------------
// gbcs_back
// Sequences the eight display bytes of each queued request into the output
// register.
// ----------------------------------------------------------------------------
module gbcs_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  gbcs_pkg::desc_t                  q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // [7:0] out_byte
    output logic [gbcs_pkg::M_TUSER_W-1:0]   m_tuser,  // [0] is_command, [1] glyph_done
    output logic                             m_tlast
);
    import gbcs_pkg::*;

    localparam logic [1:0] SLOT_PAGE = 2'd0;
    localparam logic [1:0] SLOT_COL_LO = 2'd1;
    localparam logic [1:0] SLOT_COL_HI = 2'd2;
    localparam logic [1:0] SLOT_DATA = 2'd3;

    logic [2:0]           beat_reg;
    logic                 m_tvalid_reg;
    logic [BYTE_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic                 out_free, fire, half;

    assign out_free = !m_tvalid_reg || m_tready;
    assign fire = out_free && !q_empty;
    assign half = beat_reg[2];
    assign q_pop = fire && (beat_reg == 3'd7);

    always_comb begin
        m_tdata_next = q_head.data_lo;
        m_tuser_next[TUSER_IS_CMD] = 1'b1;
        m_tuser_next[TUSER_DONE] = q_head.done;
        m_tlast_next = 1'b0;
        case (beat_reg[1:0])
            SLOT_PAGE: m_tdata_next = q_head.page_cmd + {7'd0, half};
            SLOT_COL_LO: m_tdata_next = q_head.col_lo_cmd;
            SLOT_COL_HI: m_tdata_next = q_head.col_hi_cmd;
            SLOT_DATA: begin
                m_tdata_next = half ? q_head.data_lo : q_head.data_hi;
                m_tuser_next[TUSER_IS_CMD] = 1'b0;
                m_tlast_next = half;
            end
            default: m_tdata_next = q_head.data_lo;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                beat_reg <= beat_reg + 1'b1;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign m_tlast = m_tlast_reg;

    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && m_tlast_next |-> !m_tuser_next[TUSER_IS_CMD] && q_pop)
        else $error("run end not on final data byte");

    a_pop_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> beat_reg == 3'd0)
        else $error("beat counter not realigned after pop");

endmodule

// ----- design/glyph_blit_command_stream.sv -----
// ----------------------------------------------------------------------------
// glyph_blit_command_stream
// Monochrome glyph bytes to a 2bpp display command and data byte stream.
// ----------------------------------------------------------------------------
// A taken request is written into the queue, then its first result byte is registered in the output register.
// Throughput: one result byte per cycle on m_ side while m_tready is high and a request is queued.
// A two-entry queue lets a new request be taken while a run is still output.
// Reset (aresetn low, synchronous): registers return to defaults, counters
// clear, queue and output empty.
module glyph_blit_command_stream (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel_byte
    input  logic [0:0]                     s_tuser,   // [0] glyph_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic [gbcs_pkg::M_TUSER_W-1:0] m_tuser,   // [0] is_command, [1] glyph_done
    output logic                           m_tlast
);
    import gbcs_pkg::*;

    cfg_t  cfg_reg;
    desc_t push_desc, head;
    logic  push, pop, full, empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.page_cmd_base <= 8'd96;
            cfg_reg.col_low_cmd_base <= 8'd0;
            cfg_reg.col_high_cmd_base <= 8'd16;
            cfg_reg.start_page <= 8'd0;
            cfg_reg.start_column <= 8'd0;
            cfg_reg.glyph_width <= 8'd1;
            cfg_reg.glyph_height <= 8'd1;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_PAGE_CMD_BASE: cfg_reg.page_cmd_base <= cfg_data;
                REG_COL_LOW_CMD_BASE: cfg_reg.col_low_cmd_base <= cfg_data;
                REG_COL_HIGH_CMD_BASE: cfg_reg.col_high_cmd_base <= cfg_data;
                REG_START_PAGE: cfg_reg.start_page <= cfg_data;
                REG_START_COLUMN: cfg_reg.start_column <= cfg_data;
                REG_GLYPH_WIDTH: cfg_reg.glyph_width <= cfg_data;
                REG_GLYPH_HEIGHT: cfg_reg.glyph_height <= cfg_data;
                default: ;
            endcase
        end
    end

    gbcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .q_push   (push),
        .q_desc   (push_desc)
    );

    gbcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    gbcs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
